FILE: rtl/swt_pkg.sv
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and constants of the sequence window tracker.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam int SEQ_W = 32;
  localparam int CNT_W = 32;
  localparam int VERDICT_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [VERDICT_W-1:0] {
    V_FIRST     = 3'd0,
    V_IN_ORDER  = 3'd1,
    V_REORDERED = 3'd2,
    V_DUPLICATE = 3'd3,
    V_TOO_OLD   = 3'd4
  } verdict_e;

endpackage

FILE: rtl/swt_if.sv
// ----------------------------------------------------------------------------
// swt_if
// Valid/ready channels of the sequence window tracker.
// ----------------------------------------------------------------------------
interface swt_in_if;
  import swt_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_number;

  modport source (output valid, output seq_number, input ready);
  modport sink   (input valid, input seq_number, output ready);
endinterface

interface swt_out_if;
  import swt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [CNT_W-1:0]     received_count;
  logic [CNT_W-1:0]     duplicate_count;
  logic [CNT_W-1:0]     too_old_count;
  logic [CNT_W-1:0]     reordered_count;
  logic [CNT_W-1:0]     expected_count;
  logic [CNT_W-1:0]     lost_count;

  modport source (
    output valid, output verdict, output received_count, output duplicate_count,
    output too_old_count, output reordered_count, output expected_count,
    output lost_count, input ready
  );
  modport sink (
    input valid, input verdict, input received_count, input duplicate_count,
    input too_old_count, input reordered_count, input expected_count,
    input lost_count, output ready
  );
endinterface

FILE: rtl/swt_ram.sv
// ----------------------------------------------------------------------------
// swt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/sequence_window_tracker.sv
// ----------------------------------------------------------------------------
// sequence_window_tracker
// Classifies packet sequence numbers against a sliding seen-bitmap window.
// ----------------------------------------------------------------------------
// Duplicates of the highest and too-old arrivals skip to the counter update.
// Others run two reciprocal divisions on the shared multiplier (quotient, remainder,
// fix), a full clear or partial read-modify-write map sweep on a new highest,
// then the bit update. One item at a time; the input is ready again in the cycle
// after the result is registered, also while that result waits. Reset clears
// control state and counters; the first arrival sweeps the bitmap to zero.
module sequence_window_tracker #(
  parameter int WINDOW_SIZE = 1024,
  parameter int WORD_BITS   = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swt_in_if.sink     in_i,
  swt_out_if.source  out_o
);
  import swt_pkg::*;

  localparam int NUM_WORDS = (WINDOW_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
  localparam int SLOT_W    = $clog2(WINDOW_SIZE);
  localparam int SW1       = SLOT_W + 1;
  localparam int BIT_W     = $clog2(WORD_BITS);

  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
  localparam logic [SEQ_W-1:0]  WIN32     = SEQ_W'(WINDOW_SIZE);
  localparam logic [SEQ_W-1:0]  OLD_LIMIT = SEQ_W'(33'h1_0000_0000 - 33'(WINDOW_SIZE));
  localparam logic [SEQ_W-1:0]  WB32      = SEQ_W'(WORD_BITS);
  localparam logic [SEQ_W-1:0]  WIN_RECIP = SEQ_W'(64'h1_0000_0000 / 64'(WINDOW_SIZE));
  localparam logic [SEQ_W-1:0]  WB_RECIP  = SEQ_W'(64'h1_0000_0000 / 64'(WORD_BITS));

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0_0000_0000_0001,
    ST_DECIDE = 13'b0_0000_0000_0010,
    ST_MULQ   = 13'b0_0000_0000_0100,
    ST_MULR   = 13'b0_0000_0000_1000,
    ST_FIX    = 13'b0_0000_0001_0000,
    ST_CLR    = 13'b0_0000_0010_0000,
    ST_SWP_RD = 13'b0_0000_0100_0000,
    ST_SWP_WR = 13'b0_0000_1000_0000,
    ST_SET_RD = 13'b0_0001_0000_0000,
    ST_SET_WR = 13'b0_0010_0000_0000,
    ST_UPD    = 13'b0_0100_0000_0000,
    ST_EXP    = 13'b0_1000_0000_0000,
    ST_DONE   = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [SEQ_W-1:0]  seq_q, seq_d;
  verdict_e          verd_q, verd_d;
  logic              clr_all_q, clr_all_d;
  logic              started_q, started_d;
  logic [SEQ_W-1:0]  base_q, base_d;
  logic [SEQ_W-1:0]  high_q, high_d;
  logic [SLOT_W-1:0] hi_slot_q, hi_slot_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ADDR_W-1:0] word_q, word_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [CNT_W-1:0]  rcv_q, rcv_d;
  logic [CNT_W-1:0]  dup_q, dup_d;
  logic [CNT_W-1:0]  old_q, old_d;
  logic [CNT_W-1:0]  reo_q, reo_d;
  logic [CNT_W-1:0]  exp_q, exp_d;

  logic [SEQ_W-1:0]  dvd_q, dvd_d;
  logic [SEQ_W-1:0]  quo_q, quo_d;
  logic [SEQ_W-1:0]  rem_q, rem_d;
  logic              phase_q, phase_d;

  logic [ADDR_W-1:0] wcnt_q, wcnt_d;
  logic [SW1-1:0]    sbase_q, sbase_d;

  logic              ov_q, ov_d;
  logic [VERDICT_W-1:0] o_verd_q, o_verd_d;
  logic [CNT_W-1:0]  o_rcv_q, o_rcv_d, o_dup_q, o_dup_d, o_old_q, o_old_d;
  logic [CNT_W-1:0]  o_reo_q, o_reo_d, o_exp_q, o_exp_d, o_lost_q, o_lost_d;

  // shared multiplier and quotient correction
  logic [SEQ_W-1:0]   recip;
  logic [SEQ_W-1:0]   dvsr;
  logic [SEQ_W-1:0]   mul_a;
  logic [SEQ_W-1:0]   mul_b;
  logic [2*SEQ_W-1:0] prod;
  logic               rem_ge;
  logic [SEQ_W-1:0]   rem_fix;
  logic [SEQ_W-1:0]   quo_fix;

  logic [SEQ_W-1:0]  ahead;
  logic [SEQ_W-1:0]  span;
  logic [SEQ_W-1:0]  back;
  logic [WORD_BITS-1:0] clr_mask;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  swt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // quotient estimate is exact or one short; one compare and subtract fixes it
  assign recip   = phase_q ? WB_RECIP : WIN_RECIP;
  assign dvsr    = phase_q ? WB32 : WIN32;
  assign mul_a   = (state_q == ST_MULR) ? quo_q : dvd_q;
  assign mul_b   = (state_q == ST_MULR) ? dvsr : recip;
  assign prod    = {{SEQ_W{1'b0}}, mul_a} * {{SEQ_W{1'b0}}, mul_b};
  assign rem_ge  = rem_q >= dvsr;
  assign rem_fix = rem_ge ? rem_q - dvsr : rem_q;
  assign quo_fix = rem_ge ? quo_q + SEQ_W'(1) : quo_q;

  assign ahead = seq_q - high_q;
  assign span  = high_q - base_q;
  assign back  = base_q - seq_q;

  always_comb begin
    logic [SW1-1:0] s;
    logic [SW1-1:0] lo;
    logic [SW1-1:0] hi;
    lo = SW1'(hi_slot_q);
    hi = SW1'(slot_q);
    for (int b = 0; b < WORD_BITS; b++) begin
      s = sbase_q + SW1'(b);
      if (lo < hi) begin
        clr_mask[b] = (s > lo) && (s < hi);
      end else begin
        clr_mask[b] = (s > lo) || (s < hi);
      end
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    seq_d     = seq_q;
    verd_d    = verd_q;
    clr_all_d = clr_all_q;
    started_d = started_q;
    base_d    = base_q;
    high_d    = high_q;
    hi_slot_d = hi_slot_q;
    slot_d    = slot_q;
    word_d    = word_q;
    bit_d     = bit_q;
    rcv_d     = rcv_q;
    dup_d     = dup_q;
    old_d     = old_q;
    reo_d     = reo_q;
    exp_d     = exp_q;
    dvd_d     = dvd_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    phase_d   = phase_q;
    wcnt_d    = wcnt_q;
    sbase_d   = sbase_q;
    ov_d      = ov_q;
    o_verd_d  = o_verd_q;
    o_rcv_d   = o_rcv_q;
    o_dup_d   = o_dup_q;
    o_old_d   = o_old_q;
    o_reo_d   = o_reo_q;
    o_exp_d   = o_exp_q;
    o_lost_d  = o_lost_q;
    ram_we    = 1'b0;
    ram_waddr = wcnt_q;
    ram_wdata = '0;
    ram_raddr = wcnt_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          seq_d   = in_i.seq_number;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        dvd_d     = seq_q;
        phase_d   = 1'b0;
        clr_all_d = 1'b0;
        if (!started_q) begin
          verd_d    = V_FIRST;
          clr_all_d = 1'b1;
          state_d   = ST_MULQ;
        end else if (!ahead[SEQ_W-1] && (ahead != '0)) begin
          verd_d    = V_IN_ORDER;
          clr_all_d = (ahead >= WIN32);
          state_d   = ST_MULQ;
        end else if (ahead == '0) begin
          verd_d  = V_DUPLICATE;
          state_d = ST_UPD;
        end else if (ahead <= OLD_LIMIT) begin
          verd_d  = V_TOO_OLD;
          state_d = ST_UPD;
        end else begin
          verd_d  = V_REORDERED;
          state_d = ST_MULQ;
        end
      end
      ST_MULQ: begin
        quo_d   = prod[2*SEQ_W-1:SEQ_W];
        state_d = ST_MULR;
      end
      ST_MULR: begin
        rem_d   = dvd_q - prod[SEQ_W-1:0];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        if (!phase_q) begin
          slot_d  = rem_fix[SLOT_W-1:0];
          dvd_d   = SEQ_W'(rem_fix[SLOT_W-1:0]);
          phase_d = 1'b1;
          state_d = ST_MULQ;
        end else begin
          word_d  = quo_fix[ADDR_W-1:0];
          bit_d   = rem_fix[BIT_W-1:0];
          wcnt_d  = '0;
          sbase_d = '0;
          if (verd_q == V_REORDERED) begin
            state_d = ST_SET_RD;
          end else if (clr_all_q) begin
            state_d = ST_CLR;
          end else begin
            state_d = ST_SWP_RD;
          end
        end
      end
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt_q;
        ram_wdata = '0;
        wcnt_d    = wcnt_q + ADDR_W'(1);
        if (wcnt_q == LAST_WORD) begin
          state_d = ST_SET_RD;
        end
      end
      ST_SWP_RD: begin
        ram_raddr = wcnt_q;
        state_d   = ST_SWP_WR;
      end
      ST_SWP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt_q;
        ram_wdata = ram_rdata & ~clr_mask;
        wcnt_d    = wcnt_q + ADDR_W'(1);
        sbase_d   = sbase_q + SW1'(WORD_BITS);
        state_d   = (wcnt_q == LAST_WORD) ? ST_SET_RD : ST_SWP_RD;
      end
      ST_SET_RD: begin
        ram_raddr = word_q;
        state_d   = ST_SET_WR;
      end
      ST_SET_WR: begin
        ram_waddr = word_q;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_q);
        if ((verd_q == V_REORDERED) && ram_rdata[bit_q]) begin
          verd_d = V_DUPLICATE;
        end else begin
          ram_we = 1'b1;
        end
        state_d = ST_UPD;
      end
      ST_UPD: begin
        unique case (verd_q)
          V_FIRST: begin
            started_d = 1'b1;
            base_d    = seq_q;
            high_d    = seq_q;
            hi_slot_d = slot_q;
            rcv_d     = CNT_W'(1);
          end
          V_IN_ORDER: begin
            high_d    = seq_q;
            hi_slot_d = slot_q;
            rcv_d     = sat_inc(rcv_q);
          end
          V_DUPLICATE: begin
            dup_d = sat_inc(dup_q);
          end
          V_TOO_OLD: begin
            old_d = sat_inc(old_q);
          end
          V_REORDERED: begin
            rcv_d = sat_inc(rcv_q);
            reo_d = sat_inc(reo_q);
            if (!back[SEQ_W-1] && (back != '0)) begin
              base_d = seq_q;
            end
          end
          default: begin
          end
        endcase
        state_d = ST_EXP;
      end
      ST_EXP: begin
        if (!started_q || span[SEQ_W-1]) begin
          exp_d = '0;
        end else begin
          exp_d = span + SEQ_W'(1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d     = 1'b1;
          o_verd_d = verd_q;
          o_rcv_d  = rcv_q;
          o_dup_d  = dup_q;
          o_old_d  = old_q;
          o_reo_d  = reo_q;
          o_exp_d  = exp_q;
          o_lost_d = (exp_q > rcv_q) ? exp_q - rcv_q : '0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
      base_q    <= '0;
      high_q    <= '0;
      hi_slot_q <= '0;
      rcv_q     <= '0;
      dup_q     <= '0;
      old_q     <= '0;
      reo_q     <= '0;
      phase_q   <= 1'b0;
      wcnt_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      base_q    <= base_d;
      high_q    <= high_d;
      hi_slot_q <= hi_slot_d;
      rcv_q     <= rcv_d;
      dup_q     <= dup_d;
      old_q     <= old_d;
      reo_q     <= reo_d;
      phase_q   <= phase_d;
      wcnt_q    <= wcnt_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q     <= seq_d;
    verd_q    <= verd_d;
    clr_all_q <= clr_all_d;
    slot_q    <= slot_d;
    word_q    <= word_d;
    bit_q     <= bit_d;
    exp_q     <= exp_d;
    dvd_q     <= dvd_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    sbase_q   <= sbase_d;
    o_verd_q  <= o_verd_d;
    o_rcv_q   <= o_rcv_d;
    o_dup_q   <= o_dup_d;
    o_old_q   <= o_old_d;
    o_reo_q   <= o_reo_d;
    o_exp_q   <= o_exp_d;
    o_lost_q  <= o_lost_d;
  end

  assign out_o.valid           = ov_q;
  assign out_o.verdict         = o_verd_q;
  assign out_o.received_count  = o_rcv_q;
  assign out_o.duplicate_count = o_dup_q;
  assign out_o.too_old_count   = o_old_q;
  assign out_o.reordered_count = o_reo_q;
  assign out_o.expected_count  = o_exp_q;
  assign out_o.lost_count      = o_lost_q;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sequence_window_tracker. A table of directed
// sequence numbers (wrap, half-way, window edge, base drift, full and partial
// sweeps) runs first, then random traffic that is mostly in-window with
// reorders, duplicates, stale arrivals and jumps. Every result transfer is
// compared field by field to a typed row's values or a software tracker copy.
// ----------------------------------------------------------------------------
module tb_top;
  import swt_pkg::*;

  localparam int WINDOW      = 1024;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int RAND_ITEMS  = 1280;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 120;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_AT    = 900;

  typedef struct packed {
    verdict_e         verdict;
    logic [CNT_W-1:0] received;
    logic [CNT_W-1:0] duplicate;
    logic [CNT_W-1:0] too_old;
    logic [CNT_W-1:0] reordered;
    logic [CNT_W-1:0] expected;
    logic [CNT_W-1:0] lost;
  } tally_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             typed;
    tally_t           want;
  } seq_row_t;

  localparam seq_row_t SEQ_TABLE [22] = '{
    '{32'hFFFF_FFF0, 1'b1, '{V_FIRST,     32'd1, 32'd0, 32'd0, 32'd0, 32'd1,  32'd0}},
    '{32'hFFFF_FFF0, 1'b1, '{V_DUPLICATE, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1,  32'd0}},
    '{32'hFFFF_FFF2, 1'b1, '{V_IN_ORDER,  32'd2, 32'd1, 32'd0, 32'd0, 32'd3,  32'd1}},
    '{32'h0000_0005, 1'b0, '0},
    '{32'hFFFF_FFF1, 1'b0, '0},
    '{32'hFFFF_FFEF, 1'b0, '0},
    '{32'hFFFF_FFF1, 1'b0, '0},
    '{32'hFFFF_FC05, 1'b1, '{V_TOO_OLD,   32'd5, 32'd2, 32'd1, 32'd2, 32'd23, 32'd18}},
    '{32'hFFFF_FC06, 1'b0, '0},
    '{32'h8000_0005, 1'b0, '0},
    '{32'h8000_0004, 1'b0, '0},
    '{32'h8000_0404, 1'b0, '0},
    '{32'h8000_0803, 1'b0, '0},
    '{32'h8000_0404, 1'b0, '0},
    '{32'h8000_0802, 1'b0, '0},
    '{32'h8000_0802, 1'b0, '0},
    '{32'h8000_0403, 1'b0, '0},
    '{32'h0000_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h2AAA_AAAA, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  swt_in_if  in_ch ();
  swt_out_if out_ch ();

  sequence_window_tracker #(
    .WINDOW_SIZE(WINDOW),
    .WORD_BITS  (64)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // tracker state mirror
  bit               started;
  logic [SEQ_W-1:0] base_q;
  logic [SEQ_W-1:0] high_q;
  logic [WINDOW-1:0] seen_map;
  logic [CNT_W-1:0] rcv_n, dup_n, old_n, reord_n;

  tally_t tallies[$];
  int     verdict_hits[5];
  int     seqs_sent;
  int     results_seen;
  int     mismatches;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic tally_t track_seq(input logic [SEQ_W-1:0] s);
    tally_t             r;
    logic signed [31:0] ahead;
    logic signed [31:0] span;
    logic [SEQ_W-1:0]   walk;
    r = '0;
    if (!started) begin
      started  = 1'b1;
      base_q   = s;
      high_q   = s;
      seen_map = '0;
      seen_map[s[SLOT_W-1:0]] = 1'b1;
      rcv_n    = 32'd1;
      r.verdict = V_FIRST;
    end else begin
      ahead = s - high_q;
      if (ahead > 0) begin
        if (ahead >= WINDOW) begin
          seen_map = '0;
        end else begin
          for (int k = 1; k < ahead; k++) begin
            walk = high_q + k;
            seen_map[walk[SLOT_W-1:0]] = 1'b0;
          end
        end
        high_q = s;
        seen_map[s[SLOT_W-1:0]] = 1'b1;
        rcv_n = sat_inc(rcv_n);
        r.verdict = V_IN_ORDER;
      end else if (ahead == 0) begin
        dup_n = sat_inc(dup_n);
        r.verdict = V_DUPLICATE;
      end else if (ahead <= -WINDOW) begin
        old_n = sat_inc(old_n);
        r.verdict = V_TOO_OLD;
      end else if (seen_map[s[SLOT_W-1:0]]) begin
        dup_n = sat_inc(dup_n);
        r.verdict = V_DUPLICATE;
      end else begin
        seen_map[s[SLOT_W-1:0]] = 1'b1;
        rcv_n   = sat_inc(rcv_n);
        reord_n = sat_inc(reord_n);
        span = base_q - s;
        if (span > 0) base_q = s;
        r.verdict = V_REORDERED;
      end
    end
    span = high_q - base_q;
    r.received  = rcv_n;
    r.duplicate = dup_n;
    r.too_old   = old_n;
    r.reordered = reord_n;
    r.expected  = span[31] ? 32'd0 : high_q - base_q + 32'd1;
    r.lost      = (r.expected > rcv_n) ? r.expected - rcv_n : 32'd0;
    verdict_hits[r.verdict]++;
    return r;
  endfunction

  function automatic logic [SEQ_W-1:0] pick_seq();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return high_q + $urandom_range(3, 1);
    if (roll < 60) return high_q - $urandom_range(40, 1);
    if (roll < 68) return high_q - $urandom_range(WINDOW - 1, 41);
    if (roll < 73) return high_q;
    if (roll < 78) return high_q - $urandom_range(4000, WINDOW);
    if (roll < 83) return high_q + $urandom_range(WINDOW - 1, 40);
    if (roll < 87) return high_q + $urandom_range(32'h10_0000, WINDOW);
    if (roll < 90) return high_q + 32'h8000_0000;
    if (roll < 93) return high_q + 32'h7FFF_FFFF - $urandom_range(3);
    return $urandom();
  endfunction

  task automatic flag_diff(input string field, input logic [31:0] got,
                           input logic [31:0] want);
    $display("tb_top: result %0d %s: got %h, want %h", results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic idle_gap(input bit drain, input bit quiet);
    if (drain || (!quiet && $urandom_range(99) < 33)) begin
      in_ch.valid <= 1'b0;
      if (drain) begin
        do @(posedge clk_i); while (tallies.size() != 0);
      end else begin
        @(posedge clk_i);
        while ($urandom_range(99) < 33) @(posedge clk_i);
      end
    end
  endtask

  task automatic offer_seq(input logic [SEQ_W-1:0] s, input bit typed, input tally_t want);
    tally_t pred;
    in_ch.valid      <= 1'b1;
    in_ch.seq_number <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = track_seq(s);
    tallies.push_back(typed ? want : pred);
    seqs_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender
  initial begin : sender
    started  = 1'b0;
    base_q   = '0;
    high_q   = '0;
    seen_map = '0;
    rcv_n    = '0;
    dup_n    = '0;
    old_n    = '0;
    reord_n  = '0;
    in_ch.valid      <= 1'b0;
    in_ch.seq_number <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (SEQ_TABLE[i]) begin
      idle_gap(1'b0, 1'b0);
      offer_seq(SEQ_TABLE[i].seq, SEQ_TABLE[i].typed, SEQ_TABLE[i].want);
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_gap(n == DRAIN_AT, n >= 500 && n < 700);
      offer_seq(pick_seq(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (tallies.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("tb_top: %0d sequence numbers sent, %0d results checked", seqs_sent,
             results_seen);
    $display("tb_top: first %0d, in order %0d, reordered %0d, duplicate %0d, too old %0d",
             verdict_hits[V_FIRST], verdict_hits[V_IN_ORDER], verdict_hits[V_REORDERED],
             verdict_hits[V_DUPLICATE], verdict_hits[V_TOO_OLD]);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // receiver and checker
  initial begin : receiver
    tally_t want;
    int     hold_left;
    bit     held;
    hold_left = 0;
    held      = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (tallies.size() == 0) begin
          flag_diff("unexpected transfer, verdict", 32'(out_ch.verdict), 32'd0);
        end else begin
          want = tallies.pop_front();
          if (out_ch.verdict !== want.verdict)
            flag_diff("verdict", 32'(out_ch.verdict), 32'(want.verdict));
          if (out_ch.received_count !== want.received)
            flag_diff("received_count", out_ch.received_count, want.received);
          if (out_ch.duplicate_count !== want.duplicate)
            flag_diff("duplicate_count", out_ch.duplicate_count, want.duplicate);
          if (out_ch.too_old_count !== want.too_old)
            flag_diff("too_old_count", out_ch.too_old_count, want.too_old);
          if (out_ch.reordered_count !== want.reordered)
            flag_diff("reordered_count", out_ch.reordered_count, want.reordered);
          if (out_ch.expected_count !== want.expected)
            flag_diff("expected_count", out_ch.expected_count, want.expected);
          if (out_ch.lost_count !== want.lost)
            flag_diff("lost_count", out_ch.lost_count, want.lost);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held && results_seen == HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_ni && ((results_seen >= 520 && results_seen < 720) ||
                                   $urandom_range(99) >= 33);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, tallies.size());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
rtl/swt_pkg.sv
rtl/swt_if.sv
rtl/swt_ram.sv
rtl/sequence_window_tracker.sv
tb/tb_top.sv
